// ----- rtl/spst_pkg.sv -----
// ----------------------------------------------------------------------------
// Sparse polynomial store package
// Shared constants, state machine type and the command and status structs
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package spst_pkg;

    localparam int NUM_POLYS_DEF = 16;
    localparam int MAX_TERMS_DEF = 16;

    localparam logic [2:0] OP_CREATE = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_EVAL   = 3'd2;
    localparam logic [2:0] OP_SCALE  = 3'd3;
    localparam logic [2:0] OP_DIFF   = 3'd4;
    localparam logic [2:0] OP_LIST   = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DUP       = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_FIND_RD,
        S_FIND_CMP,
        S_NEW,
        S_CNT_RD,
        S_CNT_LD,
        S_OP,
        S_ADD_RD,
        S_ADD_CMP,
        S_REM_CHK,
        S_REM_WR,
        S_INS_CHK,
        S_INS_WR,
        S_EV_CHK,
        S_EV_LD,
        S_EV_POW,
        S_EV_MUL,
        S_EV_ACC,
        S_SC_CHK,
        S_SC_MUL,
        S_SC_WR,
        S_DF_CHK,
        S_DF_LD,
        S_DF_WR,
        S_LS_RD,
        S_LS_EMIT,
        S_RESULT
    } t_state;

    typedef enum logic [1:0] {
        OFF_SAME,
        OFF_NEXT,
        OFF_PREV
    } t_term_off;

    typedef enum logic [1:0] {
        WR_MERGE,
        WR_COPY,
        WR_NEW,
        WR_PROD
    } t_wr_src;

    typedef enum logic [1:0] {
        CNT_INC,
        CNT_DEC,
        CNT_DERIV
    } t_cnt_src;

    typedef enum logic [1:0] {
        MUL_POWER,
        MUL_SCALE,
        MUL_DERIV
    } t_mul_src;

    typedef struct packed {
        logic      latch;
        logic      ld_target2;
        logic      name_rd;
        logic      pi_inc;
        logic      src_ld;
        logic      create;
        logic      cnt_rd;
        logic      tcnt_ld;
        logic      term_rd;
        t_term_off off;
        logic      term_wr;
        logic      wr_dst;
        t_wr_src   wr_src;
        logic      cnt_wr;
        t_cnt_src  cnt_src;
        logic      ti_clr;
        logic      ti_inc;
        logic      ti_dec;
        logic      ti_set_tcnt;
        logic      pos_ld;
        logic      n_clr;
        logic      n_inc;
        logic      pow_init;
        logic      pow_step;
        logic      prod_ld;
        t_mul_src  mul_src;
        logic      acc_add;
        logic      emit_final;
        logic      emit_list;
        logic [2:0] code;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       coef_zero;
        logic       name_match;
        logic       pi_last;
        logic       count_zero;
        logic       store_full;
        logic       ti_end;
        logic       ti_at_pos;
        logic       ti_last;
        logic       tcnt_full;
        logic       tcnt_zero;
        logic       rd_expo_gt;
        logic       rd_expo_eq;
        logic       sum_zero;
        logic       rd_expo_zero;
        logic       pow_done;
        logic       out_free;
    } t_stat;

endpackage

// ----- rtl/spst_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/spst_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sparse polynomial store controller
// Sequences each request through the name lookups, term walks and result it needs.
// ----------------------------------------------------------------------------
module spst_ctrl
    import spst_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state     r_state, n_state;
    logic       r_second, n_second;
    logic [2:0] r_code, n_code;
    logic       w_creating;
    t_cmd       cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_second <= 1'b0;
            r_code   <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
            r_code   <= n_code;
        end
    end

    assign w_creating = (i_stat.op == OP_CREATE) || r_second;

    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        n_code   = r_code;
        cmd      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.latch = 1'b1;
                    n_second  = 1'b0;
                    n_state   = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.op > OP_LIST || (i_stat.op == OP_ADD && i_stat.coef_zero)) begin
                    n_code  = ST_OK;
                    n_state = S_RESULT;
                end else if (i_stat.count_zero) begin
                    if (i_stat.op == OP_CREATE) begin
                        n_state = S_NEW;
                    end else begin
                        n_code  = ST_NOT_FOUND;
                        n_state = S_RESULT;
                    end
                end else begin
                    n_state = S_FIND_RD;
                end
            end
            S_FIND_RD: begin
                cmd.name_rd = 1'b1;
                n_state     = S_FIND_CMP;
            end
            S_FIND_CMP: begin
                if (i_stat.name_match) begin
                    if (w_creating) begin
                        n_code  = ST_DUP;
                        n_state = S_RESULT;
                    end else begin
                        cmd.src_ld = 1'b1;
                        n_state    = S_CNT_RD;
                    end
                end else if (i_stat.pi_last) begin
                    if (w_creating) begin
                        n_state = S_NEW;
                    end else begin
                        n_code  = ST_NOT_FOUND;
                        n_state = S_RESULT;
                    end
                end else begin
                    cmd.pi_inc = 1'b1;
                    n_state    = S_FIND_RD;
                end
            end
            S_NEW: begin
                if (i_stat.store_full) begin
                    n_code  = ST_FULL;
                    n_state = S_RESULT;
                end else begin
                    cmd.create = 1'b1;
                    if (i_stat.op == OP_CREATE) begin
                        n_code  = ST_OK;
                        n_state = S_RESULT;
                    end else begin
                        cmd.ti_clr = 1'b1;
                        cmd.n_clr  = 1'b1;
                        n_state    = S_DF_CHK;
                    end
                end
            end
            S_CNT_RD: begin
                cmd.cnt_rd = 1'b1;
                n_state    = S_CNT_LD;
            end
            S_CNT_LD: begin
                cmd.tcnt_ld = 1'b1;
                n_state     = S_OP;
            end
            S_OP: begin
                cmd.ti_clr = 1'b1;
                case (i_stat.op)
                    OP_ADD:   n_state = S_ADD_RD;
                    OP_EVAL:  n_state = S_EV_CHK;
                    OP_SCALE: n_state = S_SC_CHK;
                    OP_DIFF: begin
                        cmd.ld_target2 = 1'b1;
                        n_second       = 1'b1;
                        n_state        = S_FIND_RD;
                    end
                    OP_LIST: begin
                        if (i_stat.tcnt_zero) begin
                            n_code  = ST_EMPTY;
                            n_state = S_RESULT;
                        end else begin
                            n_state = S_LS_RD;
                        end
                    end
                    default: begin
                        n_code  = ST_OK;
                        n_state = S_RESULT;
                    end
                endcase
            end
            S_ADD_RD: begin
                if (i_stat.ti_end) begin
                    if (i_stat.tcnt_full) begin
                        n_code  = ST_FULL;
                        n_state = S_RESULT;
                    end else begin
                        cmd.pos_ld      = 1'b1;
                        cmd.ti_set_tcnt = 1'b1;
                        n_state         = S_INS_CHK;
                    end
                end else begin
                    cmd.term_rd = 1'b1;
                    cmd.off     = OFF_SAME;
                    n_state     = S_ADD_CMP;
                end
            end
            S_ADD_CMP: begin
                if (i_stat.rd_expo_gt) begin
                    cmd.ti_inc = 1'b1;
                    n_state    = S_ADD_RD;
                end else if (i_stat.rd_expo_eq) begin
                    cmd.term_wr = 1'b1;
                    cmd.wr_src  = WR_MERGE;
                    if (i_stat.sum_zero) begin
                        n_state = S_REM_CHK;
                    end else begin
                        n_code  = ST_OK;
                        n_state = S_RESULT;
                    end
                end else if (i_stat.tcnt_full) begin
                    n_code  = ST_FULL;
                    n_state = S_RESULT;
                end else begin
                    cmd.pos_ld      = 1'b1;
                    cmd.ti_set_tcnt = 1'b1;
                    n_state         = S_INS_CHK;
                end
            end
            S_REM_CHK: begin
                if (i_stat.ti_last) begin
                    cmd.cnt_wr  = 1'b1;
                    cmd.cnt_src = CNT_DEC;
                    n_code      = ST_OK;
                    n_state     = S_RESULT;
                end else begin
                    cmd.term_rd = 1'b1;
                    cmd.off     = OFF_NEXT;
                    n_state     = S_REM_WR;
                end
            end
            S_REM_WR: begin
                cmd.term_wr = 1'b1;
                cmd.wr_src  = WR_COPY;
                cmd.ti_inc  = 1'b1;
                n_state     = S_REM_CHK;
            end
            S_INS_CHK: begin
                if (i_stat.ti_at_pos) begin
                    cmd.term_wr = 1'b1;
                    cmd.wr_src  = WR_NEW;
                    cmd.cnt_wr  = 1'b1;
                    cmd.cnt_src = CNT_INC;
                    n_code      = ST_OK;
                    n_state     = S_RESULT;
                end else begin
                    cmd.term_rd = 1'b1;
                    cmd.off     = OFF_PREV;
                    n_state     = S_INS_WR;
                end
            end
            S_INS_WR: begin
                cmd.term_wr = 1'b1;
                cmd.wr_src  = WR_COPY;
                cmd.ti_dec  = 1'b1;
                n_state     = S_INS_CHK;
            end
            S_EV_CHK: begin
                if (i_stat.ti_end) begin
                    n_code  = ST_OK;
                    n_state = S_RESULT;
                end else begin
                    cmd.term_rd = 1'b1;
                    cmd.off     = OFF_SAME;
                    n_state     = S_EV_LD;
                end
            end
            S_EV_LD: begin
                cmd.pow_init = 1'b1;
                n_state      = S_EV_POW;
            end
            S_EV_POW: begin
                cmd.pow_step = 1'b1;
                if (i_stat.pow_done) begin
                    n_state = S_EV_MUL;
                end
            end
            S_EV_MUL: begin
                cmd.prod_ld = 1'b1;
                cmd.mul_src = MUL_POWER;
                n_state     = S_EV_ACC;
            end
            S_EV_ACC: begin
                cmd.acc_add = 1'b1;
                cmd.ti_inc  = 1'b1;
                n_state     = S_EV_CHK;
            end
            S_SC_CHK: begin
                if (i_stat.ti_end) begin
                    n_code  = ST_OK;
                    n_state = S_RESULT;
                end else begin
                    cmd.term_rd = 1'b1;
                    cmd.off     = OFF_SAME;
                    n_state     = S_SC_MUL;
                end
            end
            S_SC_MUL: begin
                cmd.prod_ld = 1'b1;
                cmd.mul_src = MUL_SCALE;
                n_state     = S_SC_WR;
            end
            S_SC_WR: begin
                cmd.term_wr = 1'b1;
                cmd.wr_src  = WR_PROD;
                cmd.ti_inc  = 1'b1;
                n_state     = S_SC_CHK;
            end
            S_DF_CHK: begin
                if (i_stat.ti_end) begin
                    cmd.cnt_wr  = 1'b1;
                    cmd.cnt_src = CNT_DERIV;
                    n_code      = ST_OK;
                    n_state     = S_RESULT;
                end else begin
                    cmd.term_rd = 1'b1;
                    cmd.off     = OFF_SAME;
                    n_state     = S_DF_LD;
                end
            end
            S_DF_LD: begin
                if (i_stat.rd_expo_zero) begin
                    cmd.cnt_wr  = 1'b1;
                    cmd.cnt_src = CNT_DERIV;
                    n_code      = ST_OK;
                    n_state     = S_RESULT;
                end else begin
                    cmd.prod_ld = 1'b1;
                    cmd.mul_src = MUL_DERIV;
                    n_state     = S_DF_WR;
                end
            end
            S_DF_WR: begin
                cmd.term_wr = 1'b1;
                cmd.wr_dst  = 1'b1;
                cmd.wr_src  = WR_PROD;
                cmd.n_inc   = 1'b1;
                cmd.ti_inc  = 1'b1;
                n_state     = S_DF_CHK;
            end
            S_LS_RD: begin
                cmd.term_rd = 1'b1;
                cmd.off     = OFF_SAME;
                n_state     = S_LS_EMIT;
            end
            S_LS_EMIT: begin
                if (i_stat.out_free) begin
                    cmd.emit_list = 1'b1;
                    if (i_stat.ti_last) begin
                        n_state = S_IDLE;
                    end else begin
                        cmd.ti_inc = 1'b1;
                        n_state    = S_LS_RD;
                    end
                end
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    cmd.emit_final = 1'b1;
                    cmd.code       = r_code;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ----- rtl/spst_dp.sv -----
// ----------------------------------------------------------------------------
// Sparse polynomial store datapath
// Name, count and term memories, index counters, a shared multiplier, the
// power-loop multipliers and the output register.
// ----------------------------------------------------------------------------
module spst_dp
    import spst_pkg::*;
#(
    parameter int NUM_POLYS = NUM_POLYS_DEF,
    parameter int MAX_TERMS = MAX_TERMS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic [2:0]         i_opcode,
    input  logic [7:0]         i_poly_name,
    input  logic [7:0]         i_second_name,
    input  logic signed [31:0] i_term_coef,
    input  logic [7:0]         i_term_expo,
    input  logic signed [31:0] i_operand_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_value,
    output logic [7:0]         o_out_expo,
    output logic               o_last
);

    localparam int PIW   = (NUM_POLYS > 1) ? $clog2(NUM_POLYS) : 1;
    localparam int PCW   = $clog2(NUM_POLYS + 1);
    localparam int TCW   = $clog2(MAX_TERMS + 1);
    localparam int DEPTH = NUM_POLYS * MAX_TERMS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    function automatic logic [AW-1:0] taddr(input logic [PIW-1:0] p,
                                            input logic [TCW-1:0] i);
        return AW'(p) * AW'(MAX_TERMS) + AW'(i);
    endfunction

    logic [2:0]     r_op;
    logic [7:0]     r_name2;
    logic [31:0]    r_coef;
    logic [7:0]     r_expo;
    logic [31:0]    r_opv;
    logic [7:0]     r_target;
    logic [PCW-1:0] r_count;
    logic [PIW-1:0] r_pi;
    logic [PIW-1:0] r_src;
    logic [PIW-1:0] r_dst;
    logic [TCW-1:0] r_tcnt;
    logic [TCW-1:0] r_ti;
    logic [TCW-1:0] r_pos;
    logic [TCW-1:0] r_n;
    logic [31:0]    r_acc;
    logic [31:0]    r_pw;
    logic [31:0]    r_base;
    logic [2:0]     r_bit;
    logic [31:0]    r_tcoef;
    logic [7:0]     r_texpo;
    logic [31:0]    r_tprod;
    logic           r_ovalid;
    logic [2:0]     r_status;
    logic [31:0]    r_value;
    logic [7:0]     r_oexpo;
    logic           r_last;

    logic [7:0]     w_name_rd;
    logic [TCW-1:0] w_cnt_rd;
    logic [31:0]    w_rd_coef;
    logic [7:0]     w_rd_expo;
    logic [31:0]    w_sum;
    logic [31:0]    w_pw_mul;
    logic [31:0]    w_base_sq;
    logic [31:0]    w_mul_a;
    logic [31:0]    w_mul_b;
    logic [31:0]    w_mul_p;
    logic           w_out_free;
    logic           w_ti_last;

    logic [PIW-1:0] w_name_waddr;
    logic           w_cnt_we;
    logic [PIW-1:0] w_cnt_waddr;
    logic [TCW-1:0] w_cnt_wdata;
    logic [TCW-1:0] w_roff;
    logic [AW-1:0]  w_t_raddr;
    logic [AW-1:0]  w_t_waddr;
    logic [31:0]    w_t_wcoef;
    logic [7:0]     w_t_wexpo;

    assign w_name_waddr = PIW'(r_count);

    spst_ram #(.WIDTH(8), .DEPTH(NUM_POLYS)) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.create),
        .i_waddr (w_name_waddr),
        .i_wdata (r_target),
        .i_re    (i_cmd.name_rd),
        .i_raddr (r_pi),
        .o_rdata (w_name_rd)
    );

    always_comb begin
        w_cnt_we    = i_cmd.create | i_cmd.cnt_wr;
        w_cnt_waddr = r_src;
        w_cnt_wdata = '0;
        if (i_cmd.create) begin
            w_cnt_waddr = w_name_waddr;
        end else begin
            case (i_cmd.cnt_src)
                CNT_INC:   w_cnt_wdata = r_tcnt + TCW'(1);
                CNT_DEC:   w_cnt_wdata = r_tcnt - TCW'(1);
                CNT_DERIV: begin
                    w_cnt_waddr = r_dst;
                    w_cnt_wdata = r_n;
                end
                default:   w_cnt_wdata = '0;
            endcase
        end
    end

    spst_ram #(.WIDTH(TCW), .DEPTH(NUM_POLYS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (w_cnt_waddr),
        .i_wdata (w_cnt_wdata),
        .i_re    (i_cmd.cnt_rd),
        .i_raddr (r_src),
        .o_rdata (w_cnt_rd)
    );

    always_comb begin
        case (i_cmd.off)
            OFF_NEXT: w_roff = r_ti + TCW'(1);
            OFF_PREV: w_roff = r_ti - TCW'(1);
            default:  w_roff = r_ti;
        endcase
        w_t_raddr = taddr(r_src, w_roff);
        w_t_waddr = i_cmd.wr_dst ? taddr(r_dst, r_n) : taddr(r_src, r_ti);
        case (i_cmd.wr_src)
            WR_MERGE: begin
                w_t_wcoef = w_sum;
                w_t_wexpo = w_rd_expo;
            end
            WR_COPY: begin
                w_t_wcoef = w_rd_coef;
                w_t_wexpo = w_rd_expo;
            end
            WR_NEW: begin
                w_t_wcoef = r_coef;
                w_t_wexpo = r_expo;
            end
            default: begin
                w_t_wcoef = r_tprod;
                w_t_wexpo = r_texpo;
            end
        endcase
    end

    spst_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.term_wr),
        .i_waddr (w_t_waddr),
        .i_wdata (w_t_wcoef),
        .i_re    (i_cmd.term_rd),
        .i_raddr (w_t_raddr),
        .o_rdata (w_rd_coef)
    );

    spst_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_expo_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.term_wr),
        .i_waddr (w_t_waddr),
        .i_wdata (w_t_wexpo),
        .i_re    (i_cmd.term_rd),
        .i_raddr (w_t_raddr),
        .o_rdata (w_rd_expo)
    );

    assign w_sum     = w_rd_coef + r_coef;
    assign w_pw_mul  = r_pw * r_base;
    assign w_base_sq = r_base * r_base;

    always_comb begin
        case (i_cmd.mul_src)
            MUL_SCALE: begin
                w_mul_a = w_rd_coef;
                w_mul_b = r_opv;
            end
            MUL_DERIV: begin
                w_mul_a = {24'd0, w_rd_expo};
                w_mul_b = w_rd_coef;
            end
            default: begin
                w_mul_a = r_tcoef;
                w_mul_b = r_pw;
            end
        endcase
    end

    assign w_mul_p    = w_mul_a * w_mul_b;
    assign w_out_free = !r_ovalid || !i_out_stall;
    assign w_ti_last  = (r_ti + TCW'(1)) == r_tcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.create) begin
                r_count <= r_count + PCW'(1);
            end
            if (i_cmd.emit_final || i_cmd.emit_list) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op     <= i_opcode;
            r_name2  <= i_second_name;
            r_coef   <= i_term_coef;
            r_expo   <= i_term_expo;
            r_opv    <= i_operand_value;
            r_target <= i_poly_name;
            r_pi     <= '0;
            r_acc    <= '0;
        end
        if (i_cmd.ld_target2) begin
            r_target <= r_name2;
            r_pi     <= '0;
        end
        if (i_cmd.pi_inc) begin
            r_pi <= r_pi + PIW'(1);
        end
        if (i_cmd.src_ld) begin
            r_src <= r_pi;
        end
        if (i_cmd.create) begin
            r_dst <= w_name_waddr;
        end
        if (i_cmd.tcnt_ld) begin
            r_tcnt <= w_cnt_rd;
        end
        if (i_cmd.ti_clr) begin
            r_ti <= '0;
        end else if (i_cmd.ti_set_tcnt) begin
            r_ti <= r_tcnt;
        end else if (i_cmd.ti_inc) begin
            r_ti <= r_ti + TCW'(1);
        end else if (i_cmd.ti_dec) begin
            r_ti <= r_ti - TCW'(1);
        end
        if (i_cmd.pos_ld) begin
            r_pos <= r_ti;
        end
        if (i_cmd.n_clr) begin
            r_n <= '0;
        end else if (i_cmd.n_inc) begin
            r_n <= r_n + TCW'(1);
        end
        if (i_cmd.pow_init) begin
            r_tcoef <= w_rd_coef;
            r_texpo <= w_rd_expo;
            r_pw    <= 32'd1;
            r_base  <= r_opv;
            r_bit   <= 3'd0;
        end
        if (i_cmd.pow_step) begin
            if (r_texpo[r_bit]) begin
                r_pw <= w_pw_mul;
            end
            r_base <= w_base_sq;
            r_bit  <= r_bit + 3'd1;
        end
        if (i_cmd.prod_ld) begin
            r_tprod <= w_mul_p;
            if (i_cmd.mul_src == MUL_SCALE) begin
                r_texpo <= w_rd_expo;
            end else if (i_cmd.mul_src == MUL_DERIV) begin
                r_texpo <= w_rd_expo - 8'd1;
            end
        end
        if (i_cmd.acc_add) begin
            r_acc <= r_acc + r_tprod;
        end
        if (i_cmd.emit_final) begin
            r_status <= i_cmd.code;
            r_value  <= r_acc;
            r_oexpo  <= 8'd0;
            r_last   <= 1'b1;
        end else if (i_cmd.emit_list) begin
            r_status <= ST_OK;
            r_value  <= w_rd_coef;
            r_oexpo  <= w_rd_expo;
            r_last   <= w_ti_last;
        end
    end

    always_comb begin
        o_stat              = '0;
        o_stat.op           = r_op;
        o_stat.coef_zero    = (r_coef == 32'd0);
        o_stat.name_match   = (w_name_rd == r_target);
        o_stat.pi_last      = (PCW'(r_pi) + PCW'(1)) == r_count;
        o_stat.count_zero   = (r_count == '0);
        o_stat.store_full   = (r_count == PCW'(NUM_POLYS));
        o_stat.ti_end       = (r_ti == r_tcnt);
        o_stat.ti_at_pos    = (r_ti == r_pos);
        o_stat.ti_last      = w_ti_last;
        o_stat.tcnt_full    = (r_tcnt == TCW'(MAX_TERMS));
        o_stat.tcnt_zero    = (r_tcnt == '0);
        o_stat.rd_expo_gt   = (w_rd_expo > r_expo);
        o_stat.rd_expo_eq   = (w_rd_expo == r_expo);
        o_stat.sum_zero     = (w_sum == 32'd0);
        o_stat.rd_expo_zero = (w_rd_expo == 8'd0);
        o_stat.pow_done     = (r_bit == 3'd7);
        o_stat.out_free     = w_out_free;
    end

    assign o_out_valid = r_ovalid;
    assign o_status    = r_status;
    assign o_value     = $signed(r_value);
    assign o_out_expo  = r_oexpo;
    assign o_last      = r_last;

endmodule

// ----- rtl/sparse_polynomial_store_unit.sv -----
// Operation: a lookup reads and then compares each stored name in turn. Each
// term walked is read and handled in turn; when evaluating, an eight-step
// square-and-multiply loop forms the power. One request is handled at a time.
// A list gives one result per term (ST_EMPTY if none) as the output frees up.
// Reset: synchronous active low; the store is empty and the controller idle.
// ----------------------------------------------------------------------------
// Sparse polynomial store top level
// Named sparse polynomials with terms kept in descending exponent order.
// ----------------------------------------------------------------------------
module sparse_polynomial_store_unit
    import spst_pkg::*;
#(
    parameter int NUM_POLYS = NUM_POLYS_DEF,
    parameter int MAX_TERMS = MAX_TERMS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_opcode,
    input  logic [7:0]         i_poly_name,
    input  logic [7:0]         i_second_name,
    input  logic signed [31:0] i_term_coef,
    input  logic [7:0]         i_term_expo,
    input  logic signed [31:0] i_operand_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_value,
    output logic [7:0]         o_out_expo,
    output logic               o_last
);

    t_cmd  w_cmd;
    t_stat w_stat;

    spst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    spst_dp #(
        .NUM_POLYS (NUM_POLYS),
        .MAX_TERMS (MAX_TERMS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_opcode        (i_opcode),
        .i_poly_name     (i_poly_name),
        .i_second_name   (i_second_name),
        .i_term_coef     (i_term_coef),
        .i_term_expo     (i_term_expo),
        .i_operand_value (i_operand_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_value         (o_value),
        .o_out_expo      (o_out_expo),
        .o_last          (o_last)
    );

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// Sparse polynomial store testbench
// Drives create, add, evaluate, scale, differentiate, list and unused-opcode
// requests with random gaps and output stalls, and checks every result against
// a predictor of the store kept in a scoreboard class.
// ----------------------------------------------------------------------------
module tb_top
    import spst_pkg::*;
();

    localparam int NP = 16;
    localparam int MT = 16;
    localparam int WATCH_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
        logic [7:0]  expo;
        logic        last;
    } t_result;

    class poly_scoreboard;
        int unsigned count;
        logic [7:0]  names [NP];
        int unsigned nterms [NP];
        logic [31:0] coefs [NP][MT];
        logic [7:0]  expos [NP][MT];
        t_result     pending [$];
        int          errors;

        function new();
            count = 0;
            errors = 0;
            foreach (nterms[i]) nterms[i] = 0;
        endfunction

        function int lookup(logic [7:0] nm);
            for (int i = 0; i < count; i++) if (names[i] == nm) return i;
            return -1;
        endfunction

        function logic [2:0] create_poly(logic [7:0] nm, output int slot);
            slot = -1;
            if (lookup(nm) >= 0) return ST_DUP;
            if (count >= NP) return ST_FULL;
            names[count] = nm;
            nterms[count] = 0;
            slot = count;
            count++;
            return ST_OK;
        endfunction

        function logic [2:0] insert_term(int p, logic [31:0] c, logic [7:0] e);
            int unsigned n;
            int unsigned pos;
            logic [31:0] s;
            n = nterms[p];
            pos = 0;
            while (pos < n && expos[p][pos] > e) pos++;
            if (pos < n && expos[p][pos] == e) begin
                s = coefs[p][pos] + c;
                coefs[p][pos] = s;
                if (s == 0) begin
                    for (int i = pos; i + 1 < n; i++) begin
                        coefs[p][i] = coefs[p][i+1];
                        expos[p][i] = expos[p][i+1];
                    end
                    nterms[p] = n - 1;
                end
                return ST_OK;
            end
            if (n >= MT) return ST_FULL;
            for (int i = n; i > pos; i--) begin
                coefs[p][i] = coefs[p][i-1];
                expos[p][i] = expos[p][i-1];
            end
            coefs[p][pos] = c;
            expos[p][pos] = e;
            nterms[p] = n + 1;
            return ST_OK;
        endfunction

        function void push(logic [2:0] st, logic [31:0] v, logic [7:0] e, logic l);
            t_result r;
            r.status = st;
            r.value = v;
            r.expo = e;
            r.last = l;
            pending.push_back(r);
        endfunction

        function void note_request(logic [2:0] op, logic [7:0] nm, logic [7:0] nm2,
                                   logic [31:0] c, logic [7:0] e, logic [31:0] x);
            int p;
            int q;
            int unsigned n;
            logic [31:0] acc;
            logic [31:0] pw;
            logic [2:0] st;
            if (op == OP_CREATE) begin
                push(create_poly(nm, q), 0, 0, 1);
                return;
            end
            if (op > OP_LIST || (op == OP_ADD && c == 0)) begin
                push(ST_OK, 0, 0, 1);
                return;
            end
            p = lookup(nm);
            if (p < 0) begin
                push(ST_NOT_FOUND, 0, 0, 1);
                return;
            end
            n = nterms[p];
            case (op)
                OP_ADD: push(insert_term(p, c, e), 0, 0, 1);
                OP_EVAL: begin
                    acc = 0;
                    for (int i = 0; i < n; i++) begin
                        pw = 1;
                        for (int k = 0; k < expos[p][i]; k++) pw = pw * x;
                        acc = acc + coefs[p][i] * pw;
                    end
                    push(ST_OK, acc, 0, 1);
                end
                OP_SCALE: begin
                    for (int i = 0; i < n; i++) coefs[p][i] = coefs[p][i] * x;
                    push(ST_OK, 0, 0, 1);
                end
                OP_DIFF: begin
                    st = create_poly(nm2, q);
                    if (st == ST_OK) begin
                        nterms[q] = 0;
                        for (int i = 0; i < n; i++) begin
                            if (expos[p][i] == 0) break;
                            coefs[q][nterms[q]] = {24'd0, expos[p][i]} * coefs[p][i];
                            expos[q][nterms[q]] = expos[p][i] - 8'd1;
                            nterms[q]++;
                        end
                    end
                    push(st, 0, 0, 1);
                end
                default: begin
                    if (n == 0) push(ST_EMPTY, 0, 0, 1);
                    else for (int i = 0; i < n; i++)
                        push(ST_OK, coefs[p][i], expos[p][i], i + 1 == n);
                end
            endcase
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("result mismatch: expected %p actual %p", want, got);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  opcode;
    logic [7:0]  poly_name;
    logic [7:0]  second_name;
    logic [31:0] term_coef;
    logic [7:0]  term_expo;
    logic [31:0] operand_value;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [31:0] value;
    logic [7:0]  out_expo;
    logic        last;

    poly_scoreboard board;
    int          idle_cycles;
    bit          timed_out;
    logic [7:0]  used_names [$];

    sparse_polynomial_store_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_opcode(opcode), .i_poly_name(poly_name), .i_second_name(second_name),
        .i_term_coef(term_coef), .i_term_expo(term_expo),
        .i_operand_value(operand_value),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_status(status), .o_value(value), .o_out_expo(out_expo), .o_last(last)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function int pick_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    task automatic send_request(logic [2:0] op, logic [7:0] nm, logic [7:0] nm2,
                                logic [31:0] c, logic [7:0] e, logic [31:0] x);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        poly_name <= nm;
        second_name <= nm2;
        term_coef <= c;
        term_expo <= e;
        operand_value <= x;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        board.note_request(op, nm, nm2, c, e, x);
    endtask

    task automatic idle_input();
        in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function logic [7:0] known_name();
        if (used_names.size() == 0 || $urandom_range(0, 9) == 0) return 8'($urandom);
        return used_names[$urandom_range(0, used_names.size() - 1)];
    endfunction

    function logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 5) - 2;
            1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_request();
        logic [7:0] nm;
        logic [7:0] nm2;
        int sel;
        nm = known_name();
        nm2 = 8'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 6) begin
            send_request(OP_CREATE, nm2, 0, 0, 0, 0);
            used_names.push_back(nm2);
        end else if (sel < 55) begin
            send_request(OP_ADD, nm, 8'($urandom),
                         $urandom_range(0, 15) == 0 ? 32'd0 : rand_word(),
                         $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 9)),
                         $urandom);
        end else if (sel < 67) begin
            send_request(OP_EVAL, nm, 8'($urandom), $urandom, 8'($urandom), rand_word());
        end else if (sel < 75) begin
            send_request(OP_SCALE, nm, 8'($urandom), $urandom, 8'($urandom), rand_word());
        end else if (sel < 82) begin
            send_request(OP_DIFF, nm, nm2, $urandom, 8'($urandom), $urandom);
            used_names.push_back(nm2);
        end else if (sel < 97) begin
            send_request(OP_LIST, nm, 8'($urandom), $urandom, 8'($urandom), $urandom);
        end else begin
            send_request(3'($urandom_range(6, 7)), nm, 8'($urandom), $urandom,
                         8'($urandom), $urandom);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall)
                board.check_result('{status, value, out_expo, last});
            if ($urandom_range(0, 2) == 0) out_stall <= 1'b0;
            else out_stall <= $urandom_range(0, 29) == 0 ? 1'b1 : $urandom_range(0, 3) == 0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCH_LIMIT && !timed_out) begin
                timed_out = 1'b1;
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        board = new();
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_CREATE;
        poly_name = 0;
        second_name = 0;
        term_coef = 0;
        term_expo = 0;
        operand_value = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(OP_LIST, 8'h41, 0, 0, 0, 0);
        send_request(OP_CREATE, 8'h00, 0, 0, 0, 0);
        send_request(OP_CREATE, 8'hff, 0, 0, 0, 0);
        send_request(OP_CREATE, 8'h00, 0, 0, 0, 0);
        send_request(OP_EVAL, 8'h00, 0, 0, 0, 32'd7);
        send_request(OP_LIST, 8'h00, 0, 0, 0, 0);
        send_request(OP_ADD, 8'h00, 0, 32'd0, 8'd5, 0);
        send_request(OP_ADD, 8'h00, 0, 32'h7fff_ffff, 8'd255, 0);
        send_request(OP_ADD, 8'h00, 0, 32'h8000_0000, 8'd0, 0);
        send_request(OP_ADD, 8'h00, 0, 32'd3, 8'd2, 0);
        send_request(OP_ADD, 8'h00, 0, 32'd5, 8'd2, 0);
        send_request(OP_ADD, 8'h00, 0, 32'hffff_fff8, 8'd2, 0);
        send_request(OP_ADD, 8'h00, 0, 32'hffff_ffff, 8'd128, 0);
        send_request(OP_ADD, 8'h12, 0, 32'd1, 8'd1, 0);
        send_request(OP_EVAL, 8'h00, 0, 0, 0, 32'hffff_ffff);
        send_request(OP_EVAL, 8'hff, 0, 0, 0, 32'h8000_0000);
        send_request(OP_SCALE, 8'h00, 0, 0, 0, 32'h8000_0000);
        send_request(OP_SCALE, 8'h12, 0, 0, 0, 32'd2);
        send_request(OP_DIFF, 8'h00, 8'hff, 0, 0, 0);
        send_request(OP_DIFF, 8'h00, 8'h33, 0, 0, 0);
        send_request(OP_DIFF, 8'h77, 8'h34, 0, 0, 0);
        send_request(OP_LIST, 8'h33, 0, 0, 0, 0);
        send_request(OP_LIST, 8'h00, 0, 0, 0, 0);
        send_request(3'd6, 8'h00, 8'hff, 32'hffff_ffff, 8'hff, 32'hffff_ffff);
        send_request(3'd7, 8'h00, 0, 0, 0, 0);
        used_names.push_back(8'h00);
        used_names.push_back(8'hff);
        used_names.push_back(8'h33);

        for (int n = 0; n < 205; n++) begin
            if (n == 120) begin
                idle_input();
                while (board.pending.size() != 0) @(posedge i_clk);
                for (int k = 0; k < 10; k++) send_request(OP_ADD, used_names[0], 0,
                    rand_word() | 32'd1, 8'(k * 20 + 3), 0);
                send_request(OP_LIST, used_names[0], 0, 0, 0, 0);
            end
            random_request();
        end
        for (int k = 0; k < 20; k++) send_request(OP_CREATE, 8'($urandom), 0, 0, 0, 0);
        idle_input();

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// ----- sparse_polynomial_store_unit.f -----
rtl/spst_pkg.sv
rtl/spst_ram.sv
rtl/spst_ctrl.sv
rtl/spst_dp.sv
rtl/sparse_polynomial_store_unit.sv
bench/tb_top.sv
